// ===== rtl/nsdr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsdr_pkg
// Shared widths and constants for the noise-shaped dither requantizer.
// ----------------------------------------------------------------------------
package nsdr_pkg;

    // stream field widths
    localparam int SAMPLE_IN_W  = 32;
    localparam int SAMPLE_OUT_W = 16;

    // quantizer step: low bits dropped from the 24-bit value
    localparam int Q_SHIFT = 8;

    // working width for the corrected sample, wide enough that nothing wraps
    localparam int ACC_W = 34;

    // error feedback width (errors stay within -383..382)
    localparam int ERR_W = 10;

    // dither is the difference of two 8-bit values
    localparam int DITHER_W = Q_SHIFT + 1;

    // generator constants
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_INC = 32'd1013904223;

    // rounding half and 24-bit clip bounds
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 34'sd128;
    localparam logic signed [ACC_W-1:0] CLIP_MAX   = 34'sd8388607;
    localparam logic signed [ACC_W-1:0] CLIP_MIN   = -34'sd8388608;

endpackage

// ===== rtl/nsdr_dither.sv =====
// ----------------------------------------------------------------------------
// nsdr_dither
// High-pass triangular dither source: a 32-bit LCG kept one state ahead so
// the multiply sits on its own register path; the dither is the low byte of
// the next state minus the low byte of the current state.
// ----------------------------------------------------------------------------
module nsdr_dither
    import nsdr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    output logic signed [DITHER_W-1:0] o_dither
);

    logic [31:0] r_cur;
    logic [31:0] r_next;
    logic [31:0] n_after;

    // state after r_next, used when the generator steps
    assign n_after = r_next * LCG_MUL + LCG_INC;

    // generator registers, reset to state zero and its successor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_next <= LCG_INC;
        end else if (i_advance) begin
            r_cur  <= r_next;
            r_next <= n_after;
        end
    end

    // triangular dither value
    assign o_dither = $signed({1'b0, r_next[Q_SHIFT-1:0]})
                    - $signed({1'b0, r_cur[Q_SHIFT-1:0]});

endmodule

// ===== rtl/nsdr_shaper.sv =====
// ----------------------------------------------------------------------------
// nsdr_shaper
// Error-feedback requantizer: applies the three-tap error filter, rounding
// and dither, clips to 24 bits, quantizes to 16 bits and updates the errors.
// ----------------------------------------------------------------------------
module nsdr_shaper
    import nsdr_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic                           i_source_is_32bit,
    input  logic signed [SAMPLE_IN_W-1:0]  i_sample,
    input  logic signed [DITHER_W-1:0]     i_dither,
    output logic signed [SAMPLE_OUT_W-1:0] o_sample
);

    logic signed [ERR_W-1:0] r_e0;
    logic signed [ERR_W-1:0] r_e1;
    logic signed [ERR_W-1:0] r_e2;

    logic signed [ACC_W-1:0] s_base;
    logic signed [ACC_W-1:0] s_corr;
    logic signed [ACC_W-1:0] o_round;
    logic signed [ACC_W-1:0] s_clip;
    logic signed [ACC_W-1:0] o_clip;
    logic signed [ACC_W-1:0] o_quant;
    logic signed [ACC_W-1:0] err_full;
    logic signed [ERR_W-1:0] e0_adj;
    logic signed [ERR_W-1:0] n_e1;

    // input alignment: 32-bit sources drop their low byte
    always_comb begin
        if (i_source_is_32bit) begin
            s_base = ACC_W'($signed(i_sample[SAMPLE_IN_W-1:Q_SHIFT]));
        end else begin
            s_base = ACC_W'(i_sample);
        end
    end

    // error feedback, rounding and dither
    assign s_corr  = s_base + ACC_W'(r_e0) - ACC_W'(r_e1) + ACC_W'(r_e2);
    assign o_round = s_corr + ROUND_HALF + ACC_W'(i_dither);

    // clip to the 24-bit range, limiting the corrected sample as well
    always_comb begin
        o_clip = o_round;
        s_clip = s_corr;
        if (o_round > CLIP_MAX) begin
            o_clip = CLIP_MAX;
            if (s_corr > CLIP_MAX) begin
                s_clip = CLIP_MAX;
            end
        end else if (o_round < CLIP_MIN) begin
            o_clip = CLIP_MIN;
            if (s_corr < CLIP_MIN) begin
                s_clip = CLIP_MIN;
            end
        end
    end

    // quantize and form the new error
    assign o_quant  = {o_clip[ACC_W-1:Q_SHIFT], {Q_SHIFT{1'b0}}};
    assign err_full = s_clip - o_quant;
    assign o_sample = o_clip[Q_SHIFT+SAMPLE_OUT_W-1:Q_SHIFT];

    // halve the newest error, truncating toward zero
    assign e0_adj = r_e0 + $signed({{(ERR_W-1){1'b0}}, r_e0[ERR_W-1]});
    assign n_e1   = e0_adj >>> 1;

    // error history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0 <= '0;
            r_e1 <= '0;
            r_e2 <= '0;
        end else if (i_advance) begin
            r_e2 <= r_e1;
            r_e1 <= n_e1;
            r_e0 <= err_full[ERR_W-1:0];
        end
    end

endmodule

// ===== rtl/noise_shaped_dither_requantizer.sv =====
// ----------------------------------------------------------------------------
// noise_shaped_dither_requantizer
// Requantizes 24-bit or 32-bit PCM to 16 bits with noise-shaped dither.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed sample per item in tdata[31:0], tlast marks
//   the last sample of a buffer. m_axis returns one 16-bit sample per item
//   in tdata[15:0] with tlast copied from the input.
//   The cfg channel writes source_is_32bit (i_cfg_data); write it only
//   while no items are in flight. o_cfg_ready is always high.
// Data path and throughput:
//   an accepted item is registered, shaped combinationally and registered
//   again for m_axis. One item is taken every cycle while m_axis_tready is
//   high; the error feedback and the dither generator both step once per
//   item, in the cycle the item moves to the output register.
// Reset:
//   synchronous, active low. Clears the errors, resets the generator state,
//   clears the mode bit (24-bit source) and both valid flags.
// Stall:
//   while m_axis_tready is low the result waits in the output register; one
//   more item can sit in the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module noise_shaped_dither_requantizer
    import nsdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // source_is_32bit
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
    input  logic        s_axis_tlast,   // last_in
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    output logic        m_axis_tlast    // last_out
);

    logic                           r_source_is_32bit;
    logic                           r_in_valid;
    logic signed [SAMPLE_IN_W-1:0]  r_in_sample;
    logic                           r_in_last;
    logic                           r_out_valid;
    logic signed [SAMPLE_OUT_W-1:0] r_out_sample;
    logic                           r_out_last;

    logic                           advance;
    logic signed [DITHER_W-1:0]     dither;
    logic signed [SAMPLE_OUT_W-1:0] shaped;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_is_32bit <= 1'b0;
        end else if (i_cfg_valid) begin
            r_source_is_32bit <= i_cfg_data;
        end
    end

    // item moves from input to output register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_sample <= $signed(s_axis_tdata);
            r_in_last   <= s_axis_tlast;
        end
    end

    // dither generator
    nsdr_dither u_dither (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .o_dither  (dither)
    );

    // error-feedback quantizer
    nsdr_shaper u_shaper (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_source_is_32bit (r_source_is_32bit),
        .i_sample          (r_in_sample),
        .i_dither          (dither),
        .o_sample          (shaped)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sample <= shaped;
            r_out_last   <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tlast  = r_out_last;

endmodule
